/* hw/rtl/ccc_pkg.sv */
`default_nettype none

package ccc_pkg;

  localparam int unsigned CoordW  = 24;
  localparam int unsigned RadiusW = 22;
  localparam int unsigned DeltaW  = 25;
  localparam int unsigned RsumW   = 23;
  localparam int unsigned NormW   = 16;
  localparam int unsigned DepthW  = 23;
  localparam int unsigned SqrtW   = 31;
  localparam int unsigned RemW    = 33;
  localparam int unsigned RadW    = 62;
  localparam int unsigned QuotW   = 15;
  localparam int unsigned NumW    = 48;
  localparam int unsigned DenW    = 32;

  typedef struct packed {
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by;
    logic [RadiusW-1:0]       ra;
    logic [RadiusW-1:0]       rb;
    logic signed [DeltaW-1:0] dx;
    logic signed [DeltaW-1:0] dy;
    logic [RsumW-1:0]         rsum;
    logic                     coll;
    logic                     zero;
  } ccc_geo_t;

  typedef struct packed {
    ccc_geo_t          geo;
    logic [RadW-1:0]   v;
    logic [RemW-1:0]   rem;
    logic [SqrtW-1:0]  root;
  } ccc_sqrt_t;

  typedef struct packed {
    ccc_geo_t          geo;
    logic [DepthW-1:0] depth;
    logic [NumW-1:0]   nrx;
    logic [NumW-1:0]   nry;
    logic [DenW-1:0]   den;
    logic [QuotW-1:0]  qx;
    logic [QuotW-1:0]  qy;
  } ccc_div_t;

endpackage

`default_nettype wire

/* hw/rtl/ccc_in_if.sv */
`default_nettype none

interface ccc_in_if;
  import ccc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [CoordW-1:0]  first_x;
  logic signed [CoordW-1:0]  first_y;
  logic [RadiusW-1:0]        first_radius;
  logic signed [CoordW-1:0]  second_x;
  logic signed [CoordW-1:0]  second_y;
  logic [RadiusW-1:0]        second_radius;

  modport source (output valid, first_x, first_y, first_radius, second_x, second_y,
                  second_radius, input ready);
  modport sink (input valid, first_x, first_y, first_radius, second_x, second_y,
                second_radius, output ready);
endinterface

interface ccc_out_if;
  import ccc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      colliding;
  logic signed [NormW-1:0]   normal_x;
  logic signed [NormW-1:0]   normal_y;
  logic signed [CoordW-1:0]  start_x;
  logic signed [CoordW-1:0]  start_y;
  logic signed [CoordW-1:0]  end_x;
  logic signed [CoordW-1:0]  end_y;
  logic [DepthW-1:0]         penetration;

  modport source (output valid, colliding, normal_x, normal_y, start_x, start_y, end_x,
                  end_y, penetration, input ready);
  modport sink (input valid, colliding, normal_x, normal_y, start_x, start_y, end_x,
                end_y, penetration, output ready);
endinterface

`default_nettype wire

/* hw/rtl/ccc_sqrt_step.sv */
`default_nettype none

module ccc_sqrt_step
  import ccc_pkg::*;
#(
  parameter int unsigned Step = 0
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      en_i,
  input  wire logic      valid_i,
  input  wire ccc_sqrt_t data_i,
  output logic           valid_o,
  output ccc_sqrt_t      data_o
);

  logic      valid_q;
  ccc_sqrt_t data_d, data_q;
  logic [RemW-1:0] rem_sh, trial;

  always_comb begin
    data_d = data_i;
    rem_sh = {data_i.rem[RemW-3:0], data_i.v[2*Step+1 -: 2]};
    trial  = {data_i.root, 2'b01};
    if (rem_sh >= trial) begin
      data_d.rem  = rem_sh - trial;
      data_d.root = {data_i.root[SqrtW-2:0], 1'b1};
    end else begin
      data_d.rem  = rem_sh;
      data_d.root = {data_i.root[SqrtW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

/* hw/rtl/ccc_div_step.sv */
`default_nettype none

module ccc_div_step
  import ccc_pkg::*;
#(
  parameter int unsigned Step = 0
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     en_i,
  input  wire logic     valid_i,
  input  wire ccc_div_t data_i,
  output logic          valid_o,
  output ccc_div_t      data_o
);

  logic     valid_q;
  ccc_div_t data_d, data_q;
  logic [NumW-1:0] dsh;

  always_comb begin
    data_d = data_i;
    dsh    = {{(NumW-DenW){1'b0}}, data_i.den} << Step;
    if (data_i.nrx >= dsh) begin
      data_d.nrx      = data_i.nrx - dsh;
      data_d.qx[Step] = 1'b1;
    end
    if (data_i.nry >= dsh) begin
      data_d.nry      = data_i.nry - dsh;
      data_d.qy[Step] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

/* hw/rtl/circle_circle_contact.sv */
// Two-circle contact test, fully pipelined: one circle pair is taken every cycle
// while no result is held, and passes through 53 register stages before its
// result is offered. The pipeline depth is set by the square root, which resolves one
// result bit per stage over 31 stages, and by the two normal dividers, which
// resolve one quotient bit per stage over 15 stages. A result that is not taken
// holds the whole pipeline, and input ready drops until the output transfer
// completes.
`default_nettype none

module circle_circle_contact
  import ccc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ccc_in_if.sink    in_i,
  ccc_out_if.source res_o
);

  logic en;
  logic out_valid_q;

  assign en       = !out_valid_q || res_o.ready;
  assign in_i.ready = en;

  // Differences and radius sum.
  logic     v0_q;
  ccc_geo_t g0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g0_q.ax   <= in_i.first_x;
      g0_q.ay   <= in_i.first_y;
      g0_q.bx   <= in_i.second_x;
      g0_q.by   <= in_i.second_y;
      g0_q.ra   <= in_i.first_radius;
      g0_q.rb   <= in_i.second_radius;
      g0_q.dx   <= DeltaW'(in_i.second_x) - DeltaW'(in_i.first_x);
      g0_q.dy   <= DeltaW'(in_i.second_y) - DeltaW'(in_i.first_y);
      g0_q.rsum <= RsumW'(in_i.first_radius) + RsumW'(in_i.second_radius);
      g0_q.coll <= 1'b0;
      g0_q.zero <= 1'b0;
    end
  end

  // Squares.
  logic              v1_q;
  ccc_geo_t          g1_q;
  logic [2*DeltaW-1:0] dx2_q, dy2_q;
  logic [2*RsumW-1:0]  r2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g1_q  <= g0_q;
      dx2_q <= (2*DeltaW)'($signed(g0_q.dx) * $signed(g0_q.dx));
      dy2_q <= (2*DeltaW)'($signed(g0_q.dy) * $signed(g0_q.dy));
      r2_q  <= g0_q.rsum * g0_q.rsum;
    end
  end

  // Distance test and square root setup.
  logic [2*DeltaW:0] d2;
  ccc_sqrt_t         sq_d [0:SqrtW];
  logic              sq_v [0:SqrtW];
  ccc_sqrt_t         sq_init;

  always_comb begin
    d2                = {1'b0, dx2_q} + {1'b0, dy2_q};
    sq_init.geo       = g1_q;
    sq_init.geo.coll  = d2 <= (2*DeltaW+1)'(r2_q);
    sq_init.geo.zero  = d2 == '0;
    sq_init.v         = {d2[RadW-17:0], 16'b0};
    sq_init.rem       = '0;
    sq_init.root      = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v[0] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_d[0] <= sq_init;
    end
  end

  for (genvar k = 0; k < SqrtW; k++) begin : g_sqrt
    ccc_sqrt_step #(.Step(SqrtW - 1 - k)) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_v[k]),
      .data_i  (sq_d[k]),
      .valid_o (sq_v[k+1]),
      .data_o  (sq_d[k+1])
    );
  end

  // Depth and divider setup.
  ccc_div_t          dv_d [0:QuotW];
  logic              dv_v [0:QuotW];
  ccc_div_t          dv_init;
  logic [SqrtW-1:0]  s;
  logic [CoordW-1:0] dist_rnd;
  logic [DeltaW-1:0] magx, magy;

  always_comb begin
    s        = sq_d[SqrtW].root;
    dist_rnd = CoordW'(({1'b0, s} + 32'd128) >> 8);
    magx = sq_d[SqrtW].geo.dx[DeltaW-1] ? DeltaW'(-sq_d[SqrtW].geo.dx)
                                         : DeltaW'(sq_d[SqrtW].geo.dx);
    magy = sq_d[SqrtW].geo.dy[DeltaW-1] ? DeltaW'(-sq_d[SqrtW].geo.dy)
                                         : DeltaW'(sq_d[SqrtW].geo.dy);
    dv_init.geo   = sq_d[SqrtW].geo;
    dv_init.depth = (dist_rnd <= CoordW'(sq_d[SqrtW].geo.rsum))
                    ? DepthW'(CoordW'(sq_d[SqrtW].geo.rsum) - dist_rnd) : '0;
    dv_init.nrx   = {magx, 23'b0} + NumW'(s);
    dv_init.nry   = {magy, 23'b0} + NumW'(s);
    dv_init.den   = {s, 1'b0};
    dv_init.qx    = '0;
    dv_init.qy    = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= sq_v[SqrtW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_d[0] <= dv_init;
    end
  end

  for (genvar k = 0; k < QuotW; k++) begin : g_div
    ccc_div_step #(.Step(QuotW - 1 - k)) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_v[k]),
      .data_i  (dv_d[k]),
      .valid_o (dv_v[k+1]),
      .data_o  (dv_d[k+1])
    );
  end

  // Signed normal and offset products.
  ccc_geo_t                 g4;
  logic signed [NormW-1:0]  nx, ny;
  logic                     v4_q;
  ccc_geo_t                 g4_q;
  logic signed [NormW-1:0]  nx_q, ny_q;
  logic [DepthW-1:0]        depth4_q;
  logic signed [NormW+RadiusW:0] pxb_q, pyb_q, pxa_q, pya_q;

  always_comb begin
    g4 = dv_d[QuotW].geo;
    if (g4.zero) begin
      nx = '0;
      ny = '0;
    end else begin
      nx = g4.dx[DeltaW-1] ? -$signed({1'b0, dv_d[QuotW].qx}) : $signed({1'b0, dv_d[QuotW].qx});
      ny = g4.dy[DeltaW-1] ? -$signed({1'b0, dv_d[QuotW].qy}) : $signed({1'b0, dv_d[QuotW].qy});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= dv_v[QuotW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g4_q     <= g4;
      nx_q     <= nx;
      ny_q     <= ny;
      depth4_q <= g4.zero ? '0 : dv_d[QuotW].depth;
      pxb_q    <= nx * $signed({1'b0, g4.rb});
      pyb_q    <= ny * $signed({1'b0, g4.rb});
      pxa_q    <= nx * $signed({1'b0, g4.ra});
      pya_q    <= ny * $signed({1'b0, g4.ra});
    end
  end

  // Rounded offsets.
  localparam int unsigned PW   = NormW + RadiusW + 1;
  localparam int unsigned OffW = PW - 14 + 1;

  function automatic logic signed [OffW-1:0] round_off(input logic signed [PW-1:0] p);
    logic [PW-1:0]   mag;
    logic [PW-1:0]   q;
    mag = p[PW-1] ? PW'(-p) : PW'(p);
    q   = (mag + PW'(8192)) >> 14;
    return p[PW-1] ? -$signed(OffW'(q)) : $signed(OffW'(q));
  endfunction

  logic                    v5_q;
  ccc_geo_t                g5_q;
  logic signed [NormW-1:0] nx5_q, ny5_q;
  logic [DepthW-1:0]       depth5_q;
  logic signed [OffW-1:0]  oxb_q, oyb_q, oxa_q, oya_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g5_q     <= g4_q;
      nx5_q    <= nx_q;
      ny5_q    <= ny_q;
      depth5_q <= depth4_q;
      oxb_q    <= round_off(pxb_q);
      oyb_q    <= round_off(pyb_q);
      oxa_q    <= round_off(pxa_q);
      oya_q    <= round_off(pya_q);
    end
  end

  // Contact points with saturation, then the output register.
  localparam int unsigned SumW = OffW + 2;

  function automatic logic signed [CoordW-1:0] sat_coord(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] hi, lo;
    hi = SumW'((1 << (CoordW - 1)) - 1);
    lo = -SumW'(1 << (CoordW - 1));
    if (v > hi) begin
      return hi[CoordW-1:0];
    end else if (v < lo) begin
      return lo[CoordW-1:0];
    end
    return v[CoordW-1:0];
  endfunction

  logic signed [SumW-1:0] sx, sy, ex, ey;

  always_comb begin
    sx = SumW'(g5_q.bx) - SumW'(oxb_q);
    sy = SumW'(g5_q.by) - SumW'(oyb_q);
    ex = SumW'(g5_q.ax) + SumW'(oxa_q);
    ey = SumW'(g5_q.ay) + SumW'(oya_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_o.colliding   <= g5_q.coll;
      res_o.normal_x    <= g5_q.coll ? nx5_q : '0;
      res_o.normal_y    <= g5_q.coll ? ny5_q : '0;
      res_o.start_x     <= g5_q.coll ? sat_coord(sx) : '0;
      res_o.start_y     <= g5_q.coll ? sat_coord(sy) : '0;
      res_o.end_x       <= g5_q.coll ? sat_coord(ex) : '0;
      res_o.end_y       <= g5_q.coll ? sat_coord(ey) : '0;
      res_o.penetration <= g5_q.coll ? depth5_q : '0;
    end
  end

  assign res_o.valid = out_valid_q;

endmodule

`default_nettype wire
